// ===== rtl/lgr_pkg.sv =====
// lgr_pkg: shared types, grid constants and sequencer states for the plate relaxation block
// no dependencies
`default_nettype none

package lgr_pkg;

    localparam int GRID_ROWS = 6;
    localparam int GRID_COLS = 8;
    localparam int IN_ROWS   = GRID_ROWS - 2;
    localparam int IN_COLS   = GRID_COLS - 2;
    localparam int IN_CELLS  = IN_ROWS * IN_COLS;

    localparam int ROW_W  = (IN_ROWS > 1) ? $clog2(IN_ROWS) : 1;
    localparam int COL_W  = (IN_COLS > 1) ? $clog2(IN_COLS) : 1;
    localparam int ADDR_W = (IN_CELLS > 1) ? $clog2(IN_CELLS) : 1;

    localparam int TEMP_W  = 24;
    localparam int TOL_W   = 23;
    localparam int SWEEP_W = 16;
    localparam int IDX_W   = 3;
    localparam int SUM_W   = TEMP_W + 2;

    localparam logic [SWEEP_W-1:0] MAX_SWEEPS_RESET = 16'd1000;

    typedef logic signed [TEMP_W-1:0] temp_t;
    typedef logic [TEMP_W-1:0]        change_t;
    typedef logic [TOL_W-1:0]         tol_t;
    typedef logic [SWEEP_W-1:0]       sweeps_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_UP,
        ST_RIGHT,
        ST_DOWN,
        ST_OLD,
        ST_UPD,
        ST_CHECK,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_WAIT
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/lgr_if.sv =====
// lgr_in_if, lgr_out_if: valid/ready channels for input items and result beats
// depends on lgr_pkg
`default_nettype none

interface lgr_in_if import lgr_pkg::*; ();
    logic  valid;
    logic  ready;
    temp_t top_temp;
    temp_t right_temp;
    temp_t bottom_temp;
    temp_t left_temp;
    tol_t  tolerance;

    modport source (output valid, top_temp, right_temp, bottom_temp, left_temp, tolerance,
                    input ready);
    modport sink   (input valid, top_temp, right_temp, bottom_temp, left_temp, tolerance,
                    output ready);
endinterface

interface lgr_out_if import lgr_pkg::*; ();
    logic    valid;
    logic    ready;
    idx_t    row;
    idx_t    col;
    temp_t   cell_temp;
    sweeps_t sweeps_done;
    logic    hit_cap;
    logic    last;

    modport source (output valid, row, col, cell_temp, sweeps_done, hit_cap, last,
                    input ready);
    modport sink   (input valid, row, col, cell_temp, sweeps_done, hit_cap, last,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/lgr_update.sv =====
// lgr_update: cell update unit, mean of the neighbour sum and running largest change
// depends on lgr_pkg
`default_nettype none

module lgr_update import lgr_pkg::*;
(
    input  sum_t    sum,
    input  temp_t   old_temp,
    input  change_t largest,
    output temp_t   mean,
    output change_t largest_next
);

    logic signed [TEMP_W:0] diff;
    change_t                abs_diff;

    always_comb
    begin
        mean         = TEMP_W'(sum >>> 2);
        diff         = $signed({mean[TEMP_W-1], mean}) - $signed({old_temp[TEMP_W-1], old_temp});
        abs_diff     = diff[TEMP_W] ? TEMP_W'(-diff) : TEMP_W'(diff);
        largest_next = (abs_diff > largest) ? abs_diff : largest;
    end

endmodule

`default_nettype wire

// ===== rtl/laplace_grid_relaxation.sv =====
// laplace_grid_relaxation: top level, sequencer, cell memory and shared neighbour adder
// depends on lgr_pkg, lgr_if, lgr_update
`default_nettype none

// One item at a time. After an item is taken the interior cells are cleared,
// then each sweep steps every cell through ST_UP, ST_RIGHT, ST_DOWN, ST_OLD and
// ST_UPD and ends in ST_CHECK, a sequence set by the single read port of the cell
// memory and the one adder that gathers the four neighbours. Results leave as one
// beat per cell, each read, loaded and held until taken before the next is read;
// the input is ready again the cycle after the last beat is taken.
module laplace_grid_relaxation import lgr_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    cfg_wr_en,
    input  wire sweeps_t cfg_wr_data,
    lgr_in_if.sink       in_ch,
    lgr_out_if.source    out_ch
);

    state_t state_reg, state_next;

    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ADDR_W-1:0] cell_reg, cell_next;
    sum_t              sum_reg, sum_next;
    temp_t             prev_mean_reg, prev_mean_next;
    change_t           largest_reg, largest_next;
    sweeps_t           sweeps_reg, sweeps_next;
    logic              capped_reg, capped_next;
    sweeps_t           max_sweeps_reg;

    temp_t top_reg, right_reg, bottom_reg, left_reg;
    tol_t  tol_reg;

    logic    out_valid_reg, out_valid_next;
    idx_t    out_row_reg, out_col_reg;
    temp_t   out_temp_reg;
    sweeps_t out_sweeps_reg;
    logic    out_cap_reg, out_last_reg;
    logic    out_load;

    temp_t             mem [IN_CELLS];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_raddr;
    temp_t             mem_wdata;
    temp_t             rd_data_reg;

    temp_t   operand;
    sum_t    sum_base;
    temp_t   mean;
    change_t upd_largest;
    sweeps_t cap;
    sweeps_t sweeps_inc;
    logic    in_take;
    logic    row_end, last_row, last_cell;
    logic    converged;

    assign in_take    = in_ch.valid && in_ch.ready;
    assign row_end    = (col_reg == COL_W'(IN_COLS - 1));
    assign last_row   = (row_reg == ROW_W'(IN_ROWS - 1));
    assign last_cell  = (cell_reg == ADDR_W'(IN_CELLS - 1));
    assign cap        = (max_sweeps_reg == '0) ? SWEEP_W'(1) : max_sweeps_reg;
    assign sweeps_inc = sweeps_reg + SWEEP_W'(1);
    assign converged  = (largest_reg < {1'b0, tol_reg});

    lgr_update u_update
    (
        .sum          (sum_reg),
        .old_temp     (rd_data_reg),
        .largest      (largest_reg),
        .mean         (mean),
        .largest_next (upd_largest)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (in_ch.valid) state_next = ST_CLEAR;
            ST_CLEAR:     if (last_cell) state_next = ST_UP;
            ST_UP:        state_next = ST_RIGHT;
            ST_RIGHT:     state_next = ST_DOWN;
            ST_DOWN:      state_next = ST_OLD;
            ST_OLD:       state_next = ST_UPD;
            ST_UPD:       state_next = last_cell ? ST_CHECK : ST_UP;
            ST_CHECK:
            begin
                if (converged || (sweeps_inc >= cap))
                    state_next = ST_EMIT_RD;
                else
                    state_next = ST_UP;
            end
            ST_EMIT_RD:   state_next = ST_EMIT_LD;
            ST_EMIT_LD:   state_next = ST_EMIT_WAIT;
            ST_EMIT_WAIT:
            begin
                if (out_ch.ready)
                    state_next = out_last_reg ? ST_IDLE : ST_EMIT_RD;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // datapath control
    always_comb
    begin
        row_next       = row_reg;
        col_next       = col_reg;
        cell_next      = cell_reg;
        sum_next       = sum_reg;
        prev_mean_next = prev_mean_reg;
        largest_next   = largest_reg;
        sweeps_next    = sweeps_reg;
        capped_next    = capped_reg;
        out_valid_next = out_valid_reg;
        out_load       = 1'b0;
        mem_we         = 1'b0;
        mem_wdata      = mean;
        mem_raddr      = cell_reg;
        operand        = rd_data_reg;
        sum_base       = sum_reg;

        unique case (state_reg)
            ST_UP:
            begin
                mem_raddr = cell_reg - ADDR_W'(IN_COLS);
                operand   = (col_reg == '0) ? left_reg : prev_mean_reg;
                sum_base  = '0;
            end
            ST_RIGHT:
            begin
                mem_raddr = cell_reg + ADDR_W'(1);
                operand   = (row_reg == '0) ? top_reg : rd_data_reg;
            end
            ST_DOWN:
            begin
                mem_raddr = cell_reg + ADDR_W'(IN_COLS);
                operand   = row_end ? right_reg : rd_data_reg;
            end
            ST_OLD:
            begin
                mem_raddr = cell_reg;
                operand   = last_row ? bottom_reg : rd_data_reg;
            end
            default:
            begin
                operand  = rd_data_reg;
                sum_base = sum_reg;
            end
        endcase
        sum_next = sum_base + SUM_W'(operand);

        unique case (state_reg)
            ST_IDLE:
            begin
                cell_next    = '0;
                row_next     = '0;
                col_next     = '0;
                largest_next = '0;
                sweeps_next  = '0;
                capped_next  = 1'b0;
            end
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                cell_next = last_cell ? '0 : cell_reg + ADDR_W'(1);
            end
            ST_UPD:
            begin
                mem_we         = 1'b1;
                prev_mean_next = mean;
                largest_next   = upd_largest;
                cell_next      = last_cell ? '0 : cell_reg + ADDR_W'(1);
                col_next       = row_end ? '0 : col_reg + COL_W'(1);
                if (row_end)
                    row_next = last_row ? '0 : row_reg + ROW_W'(1);
            end
            ST_CHECK:
            begin
                sweeps_next  = sweeps_inc;
                largest_next = '0;
                capped_next  = !converged;
            end
            ST_EMIT_LD:
            begin
                out_load       = 1'b1;
                out_valid_next = 1'b1;
            end
            ST_EMIT_WAIT:
            begin
                if (out_ch.ready)
                begin
                    out_valid_next = 1'b0;
                    cell_next      = last_cell ? '0 : cell_reg + ADDR_W'(1);
                    col_next       = row_end ? '0 : col_reg + COL_W'(1);
                    if (row_end)
                        row_next = last_row ? '0 : row_reg + ROW_W'(1);
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            row_reg        <= '0;
            col_reg        <= '0;
            cell_reg       <= '0;
            largest_reg    <= '0;
            sweeps_reg     <= '0;
            capped_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            max_sweeps_reg <= MAX_SWEEPS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            cell_reg      <= cell_next;
            largest_reg   <= largest_next;
            sweeps_reg    <= sweeps_next;
            capped_reg    <= capped_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                max_sweeps_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg       <= sum_next;
        prev_mean_reg <= prev_mean_next;
        if (in_take)
        begin
            top_reg    <= in_ch.top_temp;
            right_reg  <= in_ch.right_temp;
            bottom_reg <= in_ch.bottom_temp;
            left_reg   <= in_ch.left_temp;
            tol_reg    <= in_ch.tolerance;
        end
        if (out_load)
        begin
            out_row_reg    <= IDX_W'(row_reg);
            out_col_reg    <= IDX_W'(col_reg);
            out_temp_reg   <= rd_data_reg;
            out_sweeps_reg <= sweeps_reg;
            out_cap_reg    <= capped_reg;
            out_last_reg   <= last_cell;
        end
    end

    // cell memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[cell_reg] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
    end

    assign in_ch.ready        = (state_reg == ST_IDLE);
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.row         = out_row_reg;
    assign out_ch.col         = out_col_reg;
    assign out_ch.cell_temp   = out_temp_reg;
    assign out_ch.sweeps_done = out_sweeps_reg;
    assign out_ch.hit_cap     = out_cap_reg;
    assign out_ch.last        = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/lgr_checker.sv =====
// lgr_checker: port-level assertions for laplace_grid_relaxation, with its bind
// depends on lgr_pkg, laplace_grid_relaxation
`default_nettype none

module lgr_checker import lgr_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    in_valid,
    input wire logic    in_ready,
    input wire logic    out_valid,
    input wire logic    out_ready,
    input wire logic    out_last,
    input wire sweeps_t out_sweeps_done
);

    // a result beat stays offered until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    // no new item while results are still going out
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready during result delivery");

    // an accepted item closes the input until its run is done
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready && !out_valid)
        else $error("input ready right after accepting an item");

    // the final beat ends the run and every beat reports at least one sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_last |=> !out_valid && in_ready)
        else $error("run did not end after final beat");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_sweeps_done != '0)
        else $error("result beat with zero sweeps");

endmodule

bind laplace_grid_relaxation lgr_checker u_lgr_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_last        (out_ch.last),
    .out_sweeps_done (out_ch.sweeps_done)
);

`default_nettype wire

// ===== tb/sv/laplace_grid_relaxation_test.sv =====
// laplace_grid_relaxation_test: self-checking bench for the plate relaxation block, with
// its own sweep-by-sweep predictor, a queued driver and a checking monitor on the result channel
// depends on lgr_pkg, lgr_if and laplace_grid_relaxation
`default_nettype none

module laplace_grid_relaxation_test;
    import lgr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 100000;
    localparam int HOLD_CYCLES = 3000;
    localparam int MAX_SHOWN   = 10;

    localparam temp_t TEMP_MAX = temp_t'(24'h7FFFFF);
    localparam temp_t TEMP_MIN = temp_t'(24'h800000);
    localparam tol_t  TOL_MAX  = tol_t'(23'h7FFFFF);

    typedef enum {TOL_ANY, TOL_COARSE} tol_mix_t;

    typedef struct {
        temp_t top_temp;
        temp_t right_temp;
        temp_t bottom_temp;
        temp_t left_temp;
        tol_t  tolerance;
    } plate_t;

    typedef struct {
        idx_t    row;
        idx_t    col;
        temp_t   cell_temp;
        sweeps_t sweeps_done;
        logic    hit_cap;
        logic    last;
    } cell_t;

    logic    clk;
    logic    rst_n;
    logic    cfg_wr_en;
    sweeps_t cfg_wr_data;
    logic    hold_req;

    lgr_in_if  in_bus ();
    lgr_out_if out_bus ();

    laplace_grid_relaxation u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_bus),
        .out_ch      (out_bus)
    );

    plate_t  plates_waiting[$];
    cell_t   settled_cells[$];
    int      plate[IN_CELLS];
    sweeps_t sweep_cap = MAX_SWEEPS_RESET;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      hold_left;
    int      quiet_cycles;
    int      errors = 0;
    int      plates_accepted = 0;
    int      cells_checked = 0;
    int      capped_plates = 0;
    int      caps_tried = 1;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int edge_or_cell(plate_t it, int r, int c);
        if (r < 0)
            return it.top_temp;
        if (r >= IN_ROWS)
            return it.bottom_temp;
        if (c < 0)
            return it.left_temp;
        if (c >= IN_COLS)
            return it.right_temp;
        return plate[r * IN_COLS + c];
    endfunction

    // gauss-seidel sweeps in place until the largest change drops under the tolerance or the sweep cap is reached
    function automatic void relax_plate(plate_t it);
        longint total;
        int     mean;
        int     diff;
        int     worst;
        int     passes;
        int     lim;
        bit     capped;
        bit     done;
        cell_t  c;
        for (int k = 0; k < IN_CELLS; k++)
            plate[k] = 0;
        lim = (sweep_cap == 0) ? 1 : int'(sweep_cap);
        passes = 0;
        capped = 1'b0;
        done = 1'b0;
        while (!done)
        begin
            worst = 0;
            for (int r = 0; r < IN_ROWS; r++)
            begin
                for (int q = 0; q < IN_COLS; q++)
                begin
                    total = longint'(edge_or_cell(it, r - 1, q))
                          + longint'(edge_or_cell(it, r, q + 1))
                          + longint'(edge_or_cell(it, r + 1, q))
                          + longint'(edge_or_cell(it, r, q - 1));
                    mean = int'(total >>> 2);
                    diff = mean - plate[r * IN_COLS + q];
                    if (diff < 0)
                        diff = -diff;
                    if (diff > worst)
                        worst = diff;
                    plate[r * IN_COLS + q] = mean;
                end
            end
            passes++;
            if (worst < int'(it.tolerance))
                done = 1'b1;
            else if (passes >= lim)
            begin
                capped = 1'b1;
                done = 1'b1;
            end
        end
        if (capped)
            capped_plates++;
        for (int k = 0; k < IN_CELLS; k++)
        begin
            c.row         = idx_t'(k / IN_COLS);
            c.col         = idx_t'(k % IN_COLS);
            c.cell_temp   = temp_t'(plate[k]);
            c.sweeps_done = sweeps_t'(passes);
            c.hit_cap     = capped;
            c.last        = (k == IN_CELLS - 1);
            settled_cells.push_back(c);
        end
    endfunction

    // driver: one beat per plate, valid held until taken
    always @(posedge clk or negedge rst_n)
    begin
        bit     took;
        plate_t nxt;
        if (!rst_n)
        begin
            in_bus.valid       <= 1'b0;
            in_bus.top_temp    <= '0;
            in_bus.right_temp  <= '0;
            in_bus.bottom_temp <= '0;
            in_bus.left_temp   <= '0;
            in_bus.tolerance   <= '0;
        end
        else
        begin
            took = in_bus.valid && in_bus.ready;
            if (took)
            begin
                relax_plate(plates_waiting.pop_front());
                plates_accepted++;
            end
            if (!in_bus.valid || took)
            begin
                if (plates_waiting.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = plates_waiting[0];
                    in_bus.valid       <= 1'b1;
                    in_bus.top_temp    <= nxt.top_temp;
                    in_bus.right_temp  <= nxt.right_temp;
                    in_bus.bottom_temp <= nxt.bottom_temp;
                    in_bus.left_temp   <= nxt.left_temp;
                    in_bus.tolerance   <= nxt.tolerance;
                end
                else
                    in_bus.valid <= 1'b0;
            end
        end
    end

    // long result hold-off, counted in cycles
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_req)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // monitor and result-side ready
    always @(posedge clk or negedge rst_n)
    begin
        cell_t want;
        if (!rst_n)
        begin
            out_bus.ready <= 1'b0;
        end
        else
        begin
            if (out_bus.valid && out_bus.ready)
            begin
                cells_checked++;
                if (settled_cells.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_SHOWN)
                        $display("unexpected result beat: r%0d c%0d t=%0d",
                                 out_bus.row, out_bus.col, out_bus.cell_temp);
                end
                else
                begin
                    want = settled_cells.pop_front();
                    if (out_bus.row !== want.row || out_bus.col !== want.col
                        || out_bus.cell_temp !== want.cell_temp
                        || out_bus.sweeps_done !== want.sweeps_done
                        || out_bus.hit_cap !== want.hit_cap || out_bus.last !== want.last)
                    begin
                        errors++;
                        if (errors <= MAX_SHOWN)
                            $display("cell exp r%0d c%0d t=%0d s=%0d cap=%b last=%b",
                                     want.row, want.col, want.cell_temp, want.sweeps_done,
                                     want.hit_cap, want.last, "\n     got r%0d c%0d ",
                                     out_bus.row, out_bus.col, "t=%0d s=%0d cap=%b last=%b",
                                     out_bus.cell_temp, out_bus.sweeps_done,
                                     out_bus.hit_cap, out_bus.last);
                    end
                end
            end
            out_bus.ready <= !hold_req && hold_left == 0
                             && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("no beat for %0d cycles", QUIET_LIMIT);
                $display("laplace_grid_relaxation: mismatch");
                $finish;
            end
        end
    end

    function automatic temp_t rand_temp();
        int v;
        case ($urandom_range(5))
            0: v = TEMP_MAX;
            1: v = TEMP_MIN;
            2: v = int'($urandom_range(4096)) - 2048;
            default: v = $urandom;
        endcase
        return temp_t'(v);
    endfunction

    function automatic tol_t rand_tol(tol_mix_t mix);
        if (mix == TOL_COARSE)
        begin
            if ($urandom_range(1) == 0)
                return tol_t'($urandom_range(4095, 256));
            return tol_t'($urandom_range(8388607, 4096));
        end
        case ($urandom_range(9))
            0: return '0;
            1, 2: return tol_t'($urandom);
            3, 4, 5, 6: return tol_t'($urandom_range(1023, 1));
            default: return tol_t'($urandom_range(65535, 1024));
        endcase
    endfunction

    task automatic offer_plate(temp_t t, temp_t r, temp_t b, temp_t l, tol_t tol);
        plate_t p;
        p.top_temp    = t;
        p.right_temp  = r;
        p.bottom_temp = b;
        p.left_temp   = l;
        p.tolerance   = tol;
        plates_waiting.push_back(p);
    endtask

    task automatic random_plates(int n, tol_mix_t mix);
        repeat (n)
            offer_plate(rand_temp(), rand_temp(), rand_temp(), rand_temp(), rand_tol(mix));
    endtask

    task automatic drain();
        while (plates_waiting.size() != 0 || settled_cells.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_cap(sweeps_t v);
        drain();
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sweep_cap = v;
        caps_tried++;
        @(negedge clk);
    endtask

    initial
    begin
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = '0;
        hold_req           = 1'b0;
        in_bus.valid       = 1'b0;
        in_bus.top_temp    = '0;
        in_bus.right_temp  = '0;
        in_bus.bottom_temp = '0;
        in_bus.left_temp   = '0;
        in_bus.tolerance   = '0;
        out_bus.ready      = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset cap, field extremes
        offer_plate(0, 0, 0, 0, 256);
        offer_plate(TEMP_MAX, TEMP_MAX, TEMP_MAX, TEMP_MAX, 256);
        offer_plate(TEMP_MIN, TEMP_MIN, TEMP_MIN, TEMP_MIN, 256);
        offer_plate(TEMP_MAX, TEMP_MIN, TEMP_MIN, TEMP_MIN, 4096);
        offer_plate(TEMP_MIN, TEMP_MAX, 0, -1, 256);
        offer_plate(-1, -2, -3, -5, 256);
        offer_plate(1000, -7, 3, 0, TOL_MAX);
        offer_plate(TEMP_MAX, TEMP_MIN, TEMP_MAX, TEMP_MIN, 1024);

        // zero cap runs one sweep; zero tolerance, convergence on the capping sweep
        set_cap(0);
        offer_plate(rand_temp(), rand_temp(), rand_temp(), rand_temp(), 0);
        offer_plate(5, -3, 7, 1, TOL_MAX);
        offer_plate(TEMP_MAX, TEMP_MAX, TEMP_MAX, TEMP_MAX, 1);
        set_cap(1);
        offer_plate(3, 2, 1, 0, TOL_MAX);
        offer_plate(TEMP_MIN, TEMP_MIN, TEMP_MIN, TEMP_MIN, 0);
        set_cap(2);
        offer_plate(TEMP_MIN, TEMP_MAX, TEMP_MIN, TEMP_MAX, 0);
        offer_plate(rand_temp(), rand_temp(), rand_temp(), rand_temp(), 0);
        set_cap(16'hFFFF);
        offer_plate(TEMP_MAX, TEMP_MAX, TEMP_MAX, TEMP_MAX, TOL_MAX);
        offer_plate(TEMP_MIN, TEMP_MIN, TEMP_MIN, TEMP_MIN, 4096);

        set_cap(sweeps_t'($urandom_range(12, 2)));
        random_plates(50, TOL_ANY);
        set_cap(20);
        send_idle_pct = 75;
        random_plates(50, TOL_ANY);
        set_cap(4);
        send_idle_pct = 0;
        recv_stall_pct = 75;
        random_plates(50, TOL_ANY);
        set_cap(9);
        send_idle_pct = 31;
        recv_stall_pct = 31;
        random_plates(50, TOL_ANY);
        set_cap(16'hFFFF);
        random_plates(20, TOL_COARSE);

        // long result hold-off so the block backs up onto its input
        set_cap(3);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        @(posedge clk);
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        @(negedge clk);
        random_plates(30, TOL_ANY);

        drain();
        repeat (20) @(posedge clk);
        $display("%0d plates relaxed under %0d sweep caps, %0d cell beats checked",
                 plates_accepted, caps_tried, cells_checked);
        $display("%0d plates stopped at the cap, %0d errors", capped_plates, errors);
        if (errors == 0)
            $display("laplace_grid_relaxation: match");
        else
            $display("laplace_grid_relaxation: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/lgr_pkg.sv
rtl/lgr_if.sv
rtl/lgr_update.sv
rtl/laplace_grid_relaxation.sv
rtl/lgr_checker.sv
tb/sv/laplace_grid_relaxation_test.sv
